// File: sv/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// shared types and constants of the 3x3 adjugate matrix inverse
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int ELEM_W   = 32;
  localparam int NUM_ELEM = 9;

  // input item: nine elements, column-major, signed fixed point
  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_0;
    logic signed [ELEM_W-1:0] elem_1;
    logic signed [ELEM_W-1:0] elem_2;
    logic signed [ELEM_W-1:0] elem_3;
    logic signed [ELEM_W-1:0] elem_4;
    logic signed [ELEM_W-1:0] elem_5;
    logic signed [ELEM_W-1:0] elem_6;
    logic signed [ELEM_W-1:0] elem_7;
    logic signed [ELEM_W-1:0] elem_8;
  } matrix_t;

  // result item: inverse, column-major, determinant and singular flag
  typedef struct packed {
    logic signed [ELEM_W-1:0] inv_0;
    logic signed [ELEM_W-1:0] inv_1;
    logic signed [ELEM_W-1:0] inv_2;
    logic signed [ELEM_W-1:0] inv_3;
    logic signed [ELEM_W-1:0] inv_4;
    logic signed [ELEM_W-1:0] inv_5;
    logic signed [ELEM_W-1:0] inv_6;
    logic signed [ELEM_W-1:0] inv_7;
    logic signed [ELEM_W-1:0] inv_8;
    logic signed [ELEM_W-1:0] det_value;
    logic                     singular;
  } result_t;

  // cofactor i = e[A]*e[B] - e[C]*e[D]
  localparam logic [3:0] COF_A [NUM_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] COF_B [NUM_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] COF_C [NUM_ELEM] = '{4'd7, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd3};
  localparam logic [3:0] COF_D [NUM_ELEM] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd1};

endpackage

// File: sv/m3inv_matrix_if.sv
// ----------------------------------------------------------------------------
// m3inv_matrix_if
// valid/ready channel carrying one input matrix item
// ----------------------------------------------------------------------------
interface m3inv_matrix_if;
  import m3inv_pkg::*;

  logic    valid;
  logic    ready;
  matrix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/m3inv_result_if.sv
// ----------------------------------------------------------------------------
// m3inv_result_if
// valid/ready channel carrying one inverse result item
// ----------------------------------------------------------------------------
interface m3inv_result_if;
  import m3inv_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// pipelined 3x3 matrix inverse by the adjugate method in signed fixed point
// ----------------------------------------------------------------------------
// usage:
//   matrix channel takes one item of nine column-major elements; result
//   channel returns the inverse, the determinant and a singular flag.
//   an item is moved when valid and ready are both high.
// stages: front stages for products, cofactors, determinant, magnitudes
//   and divider setup, 33 restoring divider stages of one quotient bit
//   each, one rounding and saturation stage.
// throughput: one item per cycle while no stall holds the pipeline; every
//   stage is a register with a valid bit, and the nine divides run as nine
//   parallel lanes through the divider stages.
// reset: rst is synchronous; it clears every valid bit, so the pipeline and
//   the output skid register come up empty.
// stall: when the receiver holds ready low, the waiting result is parked in
//   a skid register as the pipeline advances; with the skid register full
//   the whole pipeline holds and matrix.ready is low.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  m3inv_matrix_if.sink   matrix,
  m3inv_result_if.source result
);
  import m3inv_pkg::*;

  localparam int PROD_W = 2 * ELEM_W;
  localparam int COF_W  = PROD_W + 1;
  localparam int CMAG_W = PROD_W;
  localparam int SPLIT  = ELEM_W + 1;
  localparam int LO_W   = SPLIT + 1 + ELEM_W;
  localparam int DET_W  = COF_W + ELEM_W;
  localparam int DMAG_W = DET_W - 1;
  localparam int QW     = ELEM_W + 1;
  localparam int NUM_W  = CMAG_W + 2 * FRAC_BITS;
  localparam int XW     = (NUM_W > DMAG_W + QW) ? NUM_W + 1 : DMAG_W + QW + 1;
  localparam int RND_B  = 2 * FRAC_BITS - 1;

  logic adv;
  logic signed [ELEM_W-1:0] e_in [NUM_ELEM];

  assign e_in[0] = matrix.data.elem_0;
  assign e_in[1] = matrix.data.elem_1;
  assign e_in[2] = matrix.data.elem_2;
  assign e_in[3] = matrix.data.elem_3;
  assign e_in[4] = matrix.data.elem_4;
  assign e_in[5] = matrix.data.elem_5;
  assign e_in[6] = matrix.data.elem_6;
  assign e_in[7] = matrix.data.elem_7;
  assign e_in[8] = matrix.data.elem_8;

  assign matrix.ready = adv;

  // valid bits of the front stages
  logic v1, v2, v3, v4, v5, v6;

  logic signed [PROD_W-1:0] s1_prod [2*NUM_ELEM];
  logic signed [ELEM_W-1:0] s1_col  [3];
  logic signed [COF_W-1:0]  s2_cof  [NUM_ELEM];
  logic signed [ELEM_W-1:0] s2_col  [3];
  logic signed [LO_W-1:0]   s3_lo   [3];
  logic signed [PROD_W-1:0] s3_hi   [3];
  logic signed [COF_W-1:0]  s3_cof  [NUM_ELEM];
  logic signed [DET_W-1:0]  s4_term [3];
  logic signed [COF_W-1:0]  s4_cof  [NUM_ELEM];
  logic signed [DET_W-1:0]  s5_det;
  logic signed [COF_W-1:0]  s5_cof  [NUM_ELEM];
  logic [DMAG_W-1:0]        s6_dmag;
  logic                     s6_dneg;
  logic                     s6_zero;
  logic [CMAG_W-1:0]        s6_cmag [NUM_ELEM];
  logic                     s6_cneg [NUM_ELEM];

  // absolute values for stage 6
  logic signed [DET_W-1:0] det_abs;
  logic signed [COF_W-1:0] cof_abs [NUM_ELEM];

  assign det_abs = s5_det[DET_W-1] ? -s5_det : s5_det;
  always_comb begin
    for (int l = 0; l < NUM_ELEM; l++) begin
      cof_abs[l] = s5_cof[l][COF_W-1] ? -s5_cof[l] : s5_cof[l];
    end
  end

  // front stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= matrix.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // front stage data: products, cofactors, determinant, magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        s1_prod[2*i]   <= e_in[COF_A[i]] * e_in[COF_B[i]];
        s1_prod[2*i+1] <= e_in[COF_C[i]] * e_in[COF_D[i]];
      end
      for (int k = 0; k < 3; k++) begin
        s1_col[k] <= e_in[k];
      end

      for (int i = 0; i < NUM_ELEM; i++) begin
        s2_cof[i] <= COF_W'(s1_prod[2*i]) - COF_W'(s1_prod[2*i+1]);
      end
      s2_col <= s1_col;

      // split cofactor into signed high and unsigned low halves
      for (int k = 0; k < 3; k++) begin
        s3_lo[k] <= $signed({1'b0, s2_cof[3*k][SPLIT-1:0]}) * s2_col[k];
        s3_hi[k] <= $signed(s2_cof[3*k][COF_W-1:SPLIT]) * s2_col[k];
      end
      s3_cof <= s2_cof;

      for (int k = 0; k < 3; k++) begin
        s4_term[k] <= (DET_W'(s3_hi[k]) <<< SPLIT) + DET_W'(s3_lo[k]);
      end
      s4_cof <= s3_cof;

      s5_det <= s4_term[0] + s4_term[1] + s4_term[2];
      s5_cof <= s4_cof;

      s6_dmag <= det_abs[DMAG_W-1:0];
      s6_dneg <= s5_det[DET_W-1];
      s6_zero <= (s5_det == '0);
      for (int l = 0; l < NUM_ELEM; l++) begin
        s6_cmag[l] <= cof_abs[l][CMAG_W-1:0];
        s6_cneg[l] <= s5_cof[l][COF_W-1];
      end
    end
  end

  // divider pipeline, index 0 is the setup stage
  logic                     d_v    [QW+1];
  logic [DMAG_W-1:0]        d_dmag [QW+1];
  logic signed [ELEM_W-1:0] d_detv [QW+1];
  logic                     d_zero [QW+1];
  logic [XW-1:0]            d_rem  [QW+1][NUM_ELEM];
  logic [QW-1:0]            d_quo  [QW+1][NUM_ELEM];
  logic                     d_ovf  [QW+1][NUM_ELEM];
  logic                     d_neg  [QW+1][NUM_ELEM];

  // determinant rounding to the output scale
  logic [DMAG_W-1:0] det_q;
  logic [DMAG_W-1:0] det_lim;
  logic [ELEM_W-1:0] det_mag;
  logic [ELEM_W-1:0] det_out;

  always_comb begin
    det_q   = (s6_dmag >> (2 * FRAC_BITS)) + DMAG_W'(s6_dmag[RND_B]);
    det_lim = s6_dneg ? (DMAG_W'(1) << (ELEM_W - 1)) : ((DMAG_W'(1) << (ELEM_W - 1)) - 1'b1);
    det_mag = (det_q > det_lim) ? det_lim[ELEM_W-1:0] : det_q[ELEM_W-1:0];
    det_out = s6_dneg ? (~det_mag + 1'b1) : det_mag;
  end

  // setup stage: scaled numerators and overflow check
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v[0] <= 1'b0;
    end else if (adv) begin
      d_v[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_dmag[0] <= s6_dmag;
      d_zero[0] <= s6_zero;
      d_detv[0] <= $signed(det_out);
      for (int l = 0; l < NUM_ELEM; l++) begin
        d_rem[0][l] <= XW'(s6_cmag[l]) << (2 * FRAC_BITS);
        d_quo[0][l] <= '0;
        d_ovf[0][l] <= (XW'(s6_cmag[l]) << (2 * FRAC_BITS)) >= (XW'(s6_dmag) << QW);
        d_neg[0][l] <= s6_cneg[l] ^ s6_dneg;
      end
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [XW-1:0] dsh;
    assign dsh = XW'(d_dmag[j]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[j+1] <= 1'b0;
      end else if (adv) begin
        d_v[j+1] <= d_v[j];
      end
    end

    for (genvar l = 0; l < NUM_ELEM; l++) begin : g_lane
      logic [XW:0] diff;
      assign diff = {1'b0, d_rem[j][l]} - {1'b0, dsh};

      always_ff @(posedge clk) begin
        if (adv) begin
          d_ovf[j+1][l] <= d_ovf[j][l];
          d_neg[j+1][l] <= d_neg[j][l];
          if (!diff[XW]) begin
            d_rem[j+1][l] <= diff[XW-1:0];
            d_quo[j+1][l] <= {d_quo[j][l][QW-2:0], 1'b1};
          end else begin
            d_rem[j+1][l] <= d_rem[j][l];
            d_quo[j+1][l] <= {d_quo[j][l][QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_dmag[j+1] <= d_dmag[j];
        d_detv[j+1] <= d_detv[j];
        d_zero[j+1] <= d_zero[j];
      end
    end
  end

  // rounding and saturation of each lane
  logic [ELEM_W-1:0] lane_out [NUM_ELEM];

  for (genvar l = 0; l < NUM_ELEM; l++) begin : g_round
    logic          rnd;
    logic [QW:0]   qr;
    logic [QW:0]   lim;
    logic [ELEM_W-1:0] mag;

    always_comb begin
      rnd = {d_rem[QW][l], 1'b0} >= (XW + 1)'(d_dmag[QW]);
      qr  = {1'b0, d_quo[QW][l]} + (QW + 1)'(rnd);
      lim = d_neg[QW][l] ? ((QW + 1)'(1) << (ELEM_W - 1))
                         : (((QW + 1)'(1) << (ELEM_W - 1)) - 1'b1);
      mag = (d_ovf[QW][l] || (qr > lim)) ? lim[ELEM_W-1:0] : qr[ELEM_W-1:0];
      if (d_zero[QW]) begin
        lane_out[l] = '0;
      end else if (d_neg[QW][l]) begin
        lane_out[l] = ~mag + 1'b1;
      end else begin
        lane_out[l] = mag;
      end
    end
  end

  // final result register
  logic    f_v;
  result_t f_res;
  result_t res_next;

  always_comb begin
    res_next.inv_0     = $signed(lane_out[0]);
    res_next.inv_1     = $signed(lane_out[1]);
    res_next.inv_2     = $signed(lane_out[2]);
    res_next.inv_3     = $signed(lane_out[3]);
    res_next.inv_4     = $signed(lane_out[4]);
    res_next.inv_5     = $signed(lane_out[5]);
    res_next.inv_6     = $signed(lane_out[6]);
    res_next.inv_7     = $signed(lane_out[7]);
    res_next.inv_8     = $signed(lane_out[8]);
    res_next.det_value = d_zero[QW] ? '0 : d_detv[QW];
    res_next.singular  = d_zero[QW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v <= d_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_res <= res_next;
    end
  end

  // output skid register
  logic    skid_v;
  result_t skid;

  assign adv = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (result.ready) begin
        skid_v <= 1'b0;
      end
    end else if (f_v && !result.ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) begin
      skid <= f_res;
    end
  end

  assign result.valid = skid_v | f_v;
  assign result.data  = skid_v ? skid : f_res;

endmodule

// File: sv/m3inv_checker.sv
// ----------------------------------------------------------------------------
// m3inv_checker
// port-level checks of the matrix inverse, bound to the top level
// ----------------------------------------------------------------------------
module m3inv_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               r_valid,
  input logic               r_ready,
  input m3inv_pkg::result_t r_data
);
  import m3inv_pkg::*;

  // a stalled result item stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid)
    else $error("result valid dropped while stalled");

  // a stalled result item keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> $stable(r_data))
    else $error("result payload changed while stalled");

  // singular item carries an all-zero inverse and determinant
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_data.singular |->
      r_data.inv_0 == 0 && r_data.inv_1 == 0 && r_data.inv_2 == 0 &&
      r_data.inv_3 == 0 && r_data.inv_4 == 0 && r_data.inv_5 == 0 &&
      r_data.inv_6 == 0 && r_data.inv_7 == 0 && r_data.inv_8 == 0 &&
      r_data.det_value == 0)
    else $error("singular result with nonzero payload");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !r_valid)
    else $error("result valid right after reset");

endmodule

bind matrix3x3_inverse m3inv_port_checker u_m3inv_checker (
  .clk     (clk),
  .rst     (rst),
  .r_valid (result.valid),
  .r_ready (result.ready),
  .r_data  (result.data)
);
